FILE: hdl/cns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_pkg - shared types and constants for the column nearest stretch unit
// Field widths, register codes and the flag groups passed between stages.
// ----------------------------------------------------------------------------
package cns_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEN_REG_W   = 7;
   localparam int COL_REG_W   = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int MAX_COLUMNS = 1024;
   localparam int COL_IDX_W   = 10;
   localparam int CMD_DEPTH   = 4;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd2;

   localparam logic [LEN_REG_W-1:0] OUT_LENGTH_RESET   = 7'd64;
   localparam logic [LEN_REG_W-1:0] IN_LENGTH_RESET    = 7'd64;
   localparam logic [COL_REG_W-1:0] COLUMN_COUNT_RESET = 11'd1;

   // per-command flags from the front to the back
   typedef struct packed {
      logic last_in;
      logic table_last;
   } cmd_flags_type;

   // flags carried by one result
   typedef struct packed {
      logic run_last;
      logic column_end;
      logic table_end;
   } rsp_flags_type;

endpackage

FILE: hdl/cns_ratio_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_ratio_div - restoring divider for the step ratio
// One quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module cns_ratio_div
   import cns_pkg::*;
#(
   parameter int NUM_W = 22,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
            cnt_ff  <= CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: hdl/cns_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_front - configuration, step ratio and sample classification
// Holds the registers, advances the position per sample and issues one
// command per sample: the run end index and the column/table end flags.
// ----------------------------------------------------------------------------
module cns_front
   import cns_pkg::*;
#(
   parameter int MAX_LEN   = 64,
   parameter int FRAC_BITS = 15,
   parameter int LEN_W     = 7,
   parameter int ACC_W     = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output logic [SAMPLE_W-1:0]    cmd_sample,
   output logic [LEN_W-1:0]       cmd_hi,
   output cmd_flags_type          cmd_flags,
   output logic                   restart,
   output logic [LEN_W-1:0]       eff_out_len
);

   logic [LEN_REG_W-1:0] out_len_ff;
   logic [LEN_REG_W-1:0] in_len_ff;
   logic [COL_REG_W-1:0] col_cnt_ff;
   logic                 restart_ff;
   logic [ACC_W-1:0]     ratio_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [LEN_W-1:0]     in_idx_ff;
   logic [COL_IDX_W-1:0] col_idx_ff;

   logic [LEN_W-1:0]     eff_out;
   logic [LEN_W-1:0]     eff_in;
   logic [COL_REG_W-1:0] eff_cols;
   logic                 csr_write;
   logic                 accept;
   logic [ACC_W-1:0]     acc_next;
   logic [LEN_W-1:0]     hi_raw;
   logic [LEN_W-1:0]     hi;
   logic                 last_in;
   logic                 table_last;
   logic                 div_busy;
   logic                 div_done;
   logic [ACC_W-1:0]     div_quot;

   // saturate the registers to their usable ranges
   always_comb begin
      if (out_len_ff == '0) begin
         eff_out = LEN_W'(1);
      end else if (int'(out_len_ff) > MAX_LEN) begin
         eff_out = LEN_W'(MAX_LEN);
      end else begin
         eff_out = LEN_W'(out_len_ff);
      end

      if (in_len_ff == '0) begin
         eff_in = LEN_W'(1);
      end else if (int'(in_len_ff) > int'(eff_out)) begin
         eff_in = eff_out;
      end else begin
         eff_in = LEN_W'(in_len_ff);
      end

      if (col_cnt_ff == '0) begin
         eff_cols = COL_REG_W'(1);
      end else if (int'(col_cnt_ff) > MAX_COLUMNS) begin
         eff_cols = COL_REG_W'(MAX_COLUMNS);
      end else begin
         eff_cols = col_cnt_ff;
      end
   end

   cns_ratio_div #(
      .NUM_W (ACC_W),
      .DEN_W (LEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (restart_ff),
      .numer ({eff_out, {FRAC_BITS{1'b0}}}),
      .denom (eff_in),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == CSR_OUT_LENGTH ||
                      csr_index == CSR_IN_LENGTH || csr_index == CSR_COLUMN_COUNT);
   assign req_full  = restart_ff || div_busy || div_done || cmd_full;
   assign accept    = req_push && !req_full;

   always_comb begin
      acc_next   = acc_ff + ratio_ff;
      hi_raw     = acc_next[ACC_W-1:FRAC_BITS];
      hi         = (hi_raw > eff_out) ? eff_out : hi_raw;
      last_in    = ({1'b0, in_idx_ff} + 1'b1) >= {1'b0, eff_in};
      table_last = ({1'b0, col_idx_ff} + 1'b1) >= eff_cols;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff <= OUT_LENGTH_RESET;
         in_len_ff  <= IN_LENGTH_RESET;
         col_cnt_ff <= COLUMN_COUNT_RESET;
         restart_ff <= 1'b1;
         acc_ff     <= '0;
         in_idx_ff  <= '0;
         col_idx_ff <= '0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_OUT_LENGTH:   out_len_ff <= csr_data[LEN_REG_W-1:0];
               CSR_IN_LENGTH:    in_len_ff  <= csr_data[LEN_REG_W-1:0];
               CSR_COLUMN_COUNT: col_cnt_ff <= csr_data;
               default:          ;
            endcase
            // drop any partial column and start the table over
            restart_ff <= 1'b1;
            acc_ff     <= '0;
            in_idx_ff  <= '0;
            col_idx_ff <= '0;
         end else if (accept) begin
            if (last_in) begin
               acc_ff     <= '0;
               in_idx_ff  <= '0;
               col_idx_ff <= table_last ? '0 : col_idx_ff + 1'b1;
            end else begin
               acc_ff    <= acc_next;
               in_idx_ff <= in_idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         ratio_ff <= div_quot;
      end
   end

   assign cmd_push              = accept;
   assign cmd_sample            = req_sample;
   assign cmd_hi                = hi;
   assign cmd_flags.last_in     = last_in;
   assign cmd_flags.table_last  = table_last;
   assign restart               = restart_ff;
   assign eff_out_len           = eff_out;

endmodule

FILE: hdl/cns_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_cmd_queue - short command queue between front and back
// Register-based FIFO of CMD_DEPTH entries with a flush for restarts.
// ----------------------------------------------------------------------------
module cns_cmd_queue
   import cns_pkg::*;
#(
   parameter int WIDTH = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = $clog2(CMD_DEPTH);

   logic [WIDTH-1:0] mem [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == (PTR_W + 1)'(CMD_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/cns_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_back - run expansion and result register
// Repeats the head command's sample up to its run end, zero-fills to the
// column length on a column's last sample; one result per cycle while popped.
// ----------------------------------------------------------------------------
module cns_back
   import cns_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                flush,
   input  logic [LEN_W-1:0]    eff_out_len,
   input  logic                head_valid,
   input  logic [SAMPLE_W-1:0] head_sample,
   input  logic [LEN_W-1:0]    head_hi,
   input  cmd_flags_type       head_flags,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [SAMPLE_W-1:0] rsp_value,
   output logic                rsp_run_last,
   output logic                rsp_column_end,
   output logic                rsp_table_end
);

   logic [LEN_W-1:0]    out_idx_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] value_ff;
   rsp_flags_type       flags_ff;

   logic                out_free;
   logic                go;
   logic                has_run;
   logic                has_fill;
   logic                emit;
   logic [LEN_W:0]      idx_next;
   logic                final_item;
   rsp_flags_type       flags_in;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_pop;
      go         = head_valid && out_free;
      has_run    = out_idx_ff < head_hi;
      has_fill   = head_flags.last_in && (out_idx_ff < eff_out_len);
      emit       = has_run || has_fill;
      idx_next   = {1'b0, out_idx_ff} + 1'b1;
      final_item = head_flags.last_in ? (idx_next >= {1'b0, eff_out_len})
                                      : (idx_next >= {1'b0, head_hi});
      flags_in.run_last   = final_item;
      flags_in.column_end = final_item && head_flags.last_in;
      flags_in.table_end  = final_item && head_flags.last_in && head_flags.table_last;
   end

   // a command that yields no result retires without a transfer
   assign head_pop = go && (!emit || final_item);

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (go) begin
            if (emit) begin
               rsp_valid_ff <= 1'b1;
            end
            if (head_pop && head_flags.last_in) begin
               out_idx_ff <= '0;
            end else if (emit) begin
               out_idx_ff <= idx_next[LEN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         value_ff <= has_run ? head_sample : '0;
         flags_ff <= flags_in;
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_run_last   = flags_ff.run_last;
   assign rsp_column_end = flags_ff.column_end;
   assign rsp_table_end  = flags_ff.table_end;

endmodule

FILE: hdl/column_nearest_stretch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_nearest_stretch_unit - nearest-neighbor column stretch
// Each column of in_length samples becomes out_length results by repetition.
// ----------------------------------------------------------------------------
// Usage: after reset and after every configuration write the step ratio is
// rebuilt by a bit-serial divider, with req_full held high meanwhile; a write
// also drops any partial column and restarts at column 0. The front takes one
// sample per cycle while req_full is low into a four-entry command queue; the
// back produces one result per cycle while results are popped, so a sample
// holds the back for as many results as it causes: about out_length /
// in_length, at least one, and the last sample of a column also adds the zero
// fill up to out_length. The result register reloads in the cycle it is
// popped. in_length above out_length is treated as out_length.
module column_nearest_stretch_unit
   import cns_pkg::*;
#(
   parameter int MAX_LEN   = 64,
   parameter int FRAC_BITS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SAMPLE_W-1:0]    req_sample,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [SAMPLE_W-1:0]    rsp_value,
   output logic                   rsp_run_last,
   output logic                   rsp_column_end,
   output logic                   rsp_table_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int ACC_W = LEN_W + FRAC_BITS;
   localparam int CMD_W = SAMPLE_W + LEN_W + $bits(cmd_flags_type);

   logic                cmd_full;
   logic                cmd_push;
   logic [SAMPLE_W-1:0] cmd_sample;
   logic [LEN_W-1:0]    cmd_hi;
   cmd_flags_type       cmd_flags;
   logic                restart;
   logic [LEN_W-1:0]    eff_out_len;

   logic                head_valid;
   logic [CMD_W-1:0]    head_data;
   logic                head_pop;
   logic [SAMPLE_W-1:0] head_sample;
   logic [LEN_W-1:0]    head_hi;
   cmd_flags_type       head_flags;

   cns_front #(
      .MAX_LEN   (MAX_LEN),
      .FRAC_BITS (FRAC_BITS),
      .LEN_W     (LEN_W),
      .ACC_W     (ACC_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_sample  (req_sample),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_sample  (cmd_sample),
      .cmd_hi      (cmd_hi),
      .cmd_flags   (cmd_flags),
      .restart     (restart),
      .eff_out_len (eff_out_len)
   );

   cns_cmd_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (restart),
      .push       (cmd_push),
      .push_data  ({cmd_sample, cmd_hi, cmd_flags}),
      .full       (cmd_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign {head_sample, head_hi, head_flags} = head_data;

   cns_back #(
      .LEN_W (LEN_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .flush          (restart),
      .eff_out_len    (eff_out_len),
      .head_valid     (head_valid),
      .head_sample    (head_sample),
      .head_hi        (head_hi),
      .head_flags     (head_flags),
      .head_pop       (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_value      (rsp_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_column_end (rsp_column_end),
      .rsp_table_end  (rsp_table_end)
   );

endmodule

FILE: hdl/cns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_checker - port-level checks for the column nearest stretch unit
// Watches reset, configuration restarts and the result flags over time.
// ----------------------------------------------------------------------------
module cns_checker
   import cns_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [SAMPLE_W-1:0]    rsp_value,
   input logic                   rsp_run_last,
   input logic                   rsp_column_end,
   input logic                   rsp_table_end,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   // reset leaves no result and blocks samples until the ratio is ready
   assert property (@(posedge clock) reset |=> rsp_empty && req_full)
      else $error("reset did not clear results or block samples");

   // a register write blocks samples while the ratio is rebuilt
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CSR_OUT_LENGTH ||
       csr_index == CSR_IN_LENGTH || csr_index == CSR_COLUMN_COUNT))
      |=> req_full ##1 req_full)
      else $error("samples accepted during ratio rebuild");

   // table end only on the column end, which closes a run
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_table_end) |-> (rsp_column_end && rsp_run_last))
      else $error("table end without column end");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_column_end) |-> rsp_run_last)
      else $error("column end without run end");

   // a waiting result holds until its transfer or a register write flushes it
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop && !(csr_valid && csr_ready))
      |=> (!rsp_empty && $stable(rsp_value)))
      else $error("pending result changed");

endmodule

bind column_nearest_stretch_unit cns_checker u_cns_checker (.*);

FILE: test/tb_column_nearest_stretch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_nearest_stretch_unit - regression for the column stretch unit
// Drives samples and register writes through the queue-style ports, predicts
// untyped outputs with a bit-accurate predictor of the step ratio and the
// zero fill, and compares each popped result field by field. A directed
// table covers the length and column count extremes, then randomized columns
// run under several sender and receiver stall mixes and one back-pressure phase.
// ----------------------------------------------------------------------------
module tb_column_nearest_stretch_unit;
   import cns_pkg::*;

   localparam int LEN_MAX        = 64;
   localparam int FRAC           = 15;
   localparam int ACC_W          = 22;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int DIR_ROWS       = 33;

   // index with no register behind it; a write there changes nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int TX_IDLE [4] = '{0, 63, 0, 38};
   localparam int RX_STALL [4] = '{0, 0, 63, 38};

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      rsp_flags_type       flags;
   } stretch_out_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [SAMPLE_W-1:0]    sample;
      logic                   typed;
      stretch_out_type        want;
   } stim_row_type;

   localparam stretch_out_type NO_WANT = '0;

   // want = {value, run_last, column_end, table_end}; typed rows only
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h0000, 1'b1, {16'h0000, 3'b100}},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hFFFF, 1'b1, {16'hFFFF, 3'b100}},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h001, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_IN_LENGTH,    11'h001, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h8001, 1'b1, {16'h8001, 3'b111}},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h040, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h7FFE, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_COLUMN_COUNT, 11'h002, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h00FF, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hFF00, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h000, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_IN_LENGTH,    11'h000, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h1111, 1'b1, {16'h1111, 3'b110}},
      '{ROW_CSR,    CSR_UNUSED,       11'h555, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h2222, 1'b1, {16'h2222, 3'b111}},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h007, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_IN_LENGTH,    11'h003, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hA5A5, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h5A5A, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hC3C3, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h005, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_IN_LENGTH,    11'h064, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h0F0F, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hF0F0, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h3333, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hCCCC, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_OUT_LENGTH,   11'h7FF, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_IN_LENGTH,    11'h7C0, 16'h0000, 1'b0, NO_WANT},
      '{ROW_CSR,    CSR_COLUMN_COUNT, 11'h7FF, 16'h0000, 1'b0, NO_WANT},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h1357, 1'b1, {16'h1357, 3'b100}},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'hFDB9, 1'b1, {16'hFDB9, 3'b100}},
      '{ROW_SAMPLE, CSR_OUT_LENGTH,   11'h000, 16'h2468, 1'b1, {16'h2468, 3'b100}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_value;
   logic                   rsp_run_last;
   logic                   rsp_column_end;
   logic                   rsp_table_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // stretch state mirrored from the block
   logic [LEN_REG_W-1:0] reg_out_len = OUT_LENGTH_RESET;
   logic [LEN_REG_W-1:0] reg_in_len  = IN_LENGTH_RESET;
   logic [COL_REG_W-1:0] reg_columns = COLUMN_COUNT_RESET;
   logic [ACC_W-1:0]     step_ratio;
   logic [ACC_W-1:0]     position;
   logic [LEN_REG_W-1:0] in_count;
   logic [LEN_REG_W-1:0] out_count;
   logic [COL_IDX_W-1:0] column;

   stretch_out_type expected_outputs [$];
   int              error_count = 0;
   int              popped_count = 0;
   int              rx_stall_pct = 0;
   int              hold_request = 0;
   int              hold_served = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;

   column_nearest_stretch_unit #(
      .MAX_LEN   (LEN_MAX),
      .FRAC_BITS (FRAC)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_sample     (req_sample),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_value      (rsp_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_column_end (rsp_column_end),
      .rsp_table_end  (rsp_table_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [LEN_REG_W-1:0] eff_out_len();
      if (reg_out_len == 0) return 7'd1;
      if (reg_out_len > LEN_MAX) return 7'(LEN_MAX);
      return reg_out_len;
   endfunction

   function automatic logic [LEN_REG_W-1:0] eff_in_len();
      logic [LEN_REG_W-1:0] olen;
      olen = eff_out_len();
      if (reg_in_len == 0) return 7'd1;
      if (reg_in_len > olen) return olen;
      return reg_in_len;
   endfunction

   function automatic logic [COL_REG_W-1:0] eff_columns();
      if (reg_columns == 0) return 11'd1;
      if (reg_columns > MAX_COLUMNS) return 11'(MAX_COLUMNS);
      return reg_columns;
   endfunction

   function automatic void restart_table();
      step_ratio = (ACC_W'(eff_out_len()) << FRAC) / ACC_W'(eff_in_len());
      position   = '0;
      in_count   = '0;
      out_count  = '0;
      column     = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_OUT_LENGTH:   reg_out_len = data[LEN_REG_W-1:0];
         CSR_IN_LENGTH:    reg_in_len = data[LEN_REG_W-1:0];
         CSR_COLUMN_COUNT: reg_columns = data;
         default:          return;
      endcase
      restart_table();
   endfunction

   // Repeat one sample up to the truncated new position, then zero fill on
   // the last sample of a column.
   function automatic void stretch_sample(input logic [SAMPLE_W-1:0] s,
                                          ref stretch_out_type runs [$]);
      logic [ACC_W-1:0]     next_pos;
      logic [ACC_W-1:0]     reach;
      logic [LEN_REG_W-1:0] olen;
      logic [LEN_REG_W-1:0] ilen;
      logic                 last_in;
      logic                 last_column;
      stretch_out_type      r;
      runs.delete();
      olen = eff_out_len();
      ilen = eff_in_len();
      next_pos = position + step_ratio;
      reach = next_pos >> FRAC;
      if (reach > ACC_W'(olen)) reach = ACC_W'(olen);
      r = '0;
      r.value = s;
      while (ACC_W'(out_count) < reach) begin
         runs.push_back(r);
         out_count++;
      end
      position = next_pos;
      in_count++;
      last_in = (in_count >= ilen);
      last_column = ({1'b0, column} + 11'd1 >= eff_columns());
      if (last_in) begin
         r.value = '0;
         while (out_count < olen) begin
            runs.push_back(r);
            out_count++;
         end
      end
      if (runs.size() > 0) begin
         runs[runs.size()-1].flags.run_last = 1'b1;
         if (last_in) begin
            runs[runs.size()-1].flags.column_end = 1'b1;
            runs[runs.size()-1].flags.table_end = last_column;
         end
      end
      if (last_in) begin
         position  = '0;
         in_count  = '0;
         out_count = '0;
         column    = last_column ? '0 : column + 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] result %0d: %s", $realtime, popped_count, msg);
   endtask

   task automatic check_result();
      stretch_out_type want;
      if (expected_outputs.size() == 0) begin
         report_mismatch($sformatf("value %h arrived with nothing expected", rsp_value));
      end else begin
         want = expected_outputs.pop_front();
         if (rsp_value !== want.value)
            report_mismatch($sformatf("value %h, want %h", rsp_value, want.value));
         if (rsp_run_last !== want.flags.run_last)
            report_mismatch($sformatf("run_last %b, want %b", rsp_run_last,
                                      want.flags.run_last));
         if (rsp_column_end !== want.flags.column_end)
            report_mismatch($sformatf("column_end %b, want %b", rsp_column_end,
                                      want.flags.column_end));
         if (rsp_table_end !== want.flags.table_end)
            report_mismatch($sformatf("table_end %b, want %b", rsp_table_end,
                                      want.flags.table_end));
      end
      popped_count++;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                              input stretch_out_type want);
      stretch_out_type runs [$];
      req_push   <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_full !== 1'b0);
      stretch_sample(s, runs);
      if (typed) begin
         runs.delete();
         runs.push_back(want);
      end
      foreach (runs[k]) expected_outputs.push_back(runs[k]);
   endtask

   // Drop push and hold until every expected result has been popped.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(input csr_write_type writes [$]);
      wait_drained();
      foreach (writes[k]) begin
         csr_valid <= 1'b1;
         csr_index <= writes[k].index;
         csr_data  <= writes[k].data;
         do @(posedge clock); while (csr_ready !== 1'b1);
         apply_csr(writes[k].index, writes[k].data);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void pick_config(ref csr_write_type writes [$]);
      logic [LEN_REG_W-1:0] out_sel;
      logic [LEN_REG_W-1:0] in_sel;
      logic [COL_REG_W-1:0] col_sel;
      int                   in_top;
      case ($urandom_range(9))
         0:       out_sel = '0;
         1:       out_sel = 7'(LEN_MAX);
         2:       out_sel = 7'($urandom_range(65, 127));
         default: out_sel = 7'($urandom_range(1, 12));
      endcase
      in_top = (out_sel >= 1 && out_sel <= 12) ? out_sel : 12;
      case ($urandom_range(9))
         0:       in_sel = '0;
         1:       in_sel = 7'($urandom_range(65, 127));
         default: in_sel = 7'($urandom_range(1, in_top));
      endcase
      case ($urandom_range(7))
         0:       col_sel = '0;
         1:       col_sel = 11'($urandom_range(1025, 2047));
         2:       col_sel = 11'(MAX_COLUMNS);
         default: col_sel = 11'($urandom_range(1, 3));
      endcase
      writes.delete();
      writes.push_back('{CSR_OUT_LENGTH, {4'($urandom), out_sel}});
      writes.push_back('{CSR_IN_LENGTH, {4'($urandom), in_sel}});
      writes.push_back('{CSR_COLUMN_COUNT, col_sel});
   endfunction

   // receiver: random pops, plus one long hold-off when requested
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_result();
      if (hold_served != hold_request) begin
         hold_served <= hold_request;
         hold_left   <= HOLD_CYCLES;
         rsp_pop     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("column_nearest_stretch_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      csr_write_type       writes [$];
      logic [SAMPLE_W-1:0] s;
      int                  i;
      int                  n;
      int                  ilen;
      int                  tx_idle_pct;
      restart_table();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table; adjacent register rows go out as one burst
      i = 0;
      while (i < DIR_ROWS) begin
         if (DIR_TABLE[i].kind == ROW_CSR) begin
            writes.delete();
            while (i < DIR_ROWS && DIR_TABLE[i].kind == ROW_CSR) begin
               writes.push_back('{DIR_TABLE[i].index, DIR_TABLE[i].data});
               i++;
            end
            program_regs(writes);
         end else begin
            send_sample(DIR_TABLE[i].sample, DIR_TABLE[i].typed, DIR_TABLE[i].want);
            i++;
         end
      end

      // random columns under each stall mix
      for (int m = 0; m < 4; m++) begin
         tx_idle_pct = TX_IDLE[m];
         rx_stall_pct <= RX_STALL[m];
         for (int c = 0; c < 2; c++) begin
            pick_config(writes);
            program_regs(writes);
            ilen = eff_in_len();
            n = ilen * $urandom_range(1, 3);
            if (n > 40) n = ilen;
            // sometimes add up to one more column; a partial one is dropped by the next write
            if ($urandom_range(3) == 0) n += $urandom_range(1, ilen);
            repeat (n) begin
               s = ($urandom_range(15) == 0) ? {SAMPLE_W{1'b1}} : SAMPLE_W'($urandom);
               send_sample(s, 1'b0, NO_WANT);
               if ($urandom_range(99) < tx_idle_pct) begin
                  req_push <= 1'b0;
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
            end
         end
      end

      // back-pressure: hold the result side long enough that the input stalls
      rx_stall_pct <= 0;
      writes.delete();
      writes.push_back('{CSR_OUT_LENGTH, 11'd16});
      writes.push_back('{CSR_IN_LENGTH, 11'd2});
      writes.push_back('{CSR_COLUMN_COUNT, 11'd3});
      program_regs(writes);
      hold_request <= hold_request + 1;
      repeat (14) send_sample(SAMPLE_W'($urandom), 1'b0, NO_WANT);
      wait_drained();
      repeat (6) send_sample(SAMPLE_W'($urandom), 1'b0, NO_WANT);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("column_nearest_stretch_unit regression: pass");
      end else begin
         $display("column_nearest_stretch_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/cns_pkg.sv
hdl/cns_ratio_div.sv
hdl/cns_front.sv
hdl/cns_cmd_queue.sv
hdl/cns_back.sv
hdl/column_nearest_stretch_unit.sv
hdl/cns_checker.sv
test/tb_column_nearest_stretch_unit.sv
